// ===== hw/rtl/pad_pkg.sv =====
// ----------------------------------------------------------------------------
// pad_pkg
// Shared widths, constants, register indexes and helpers for the point
// attractor displacement pipeline.
// ----------------------------------------------------------------------------
package pad_pkg;

  localparam int FRAC_BITS = 16;

  localparam int XY_W  = 32;             // position and target words
  localparam int R_W   = 31;             // radius and axis distance
  localparam int DT_W  = 31;             // time step
  localparam int STR_W = 32;             // |strength|
  localparam int D2_W  = 64;             // squared distance
  localparam int SQ_N  = D2_W / 2;       // root bits, one per sqrt stage
  localparam int SQ_REM_W = SQ_N + 3;

  localparam longint unsigned ONE_L     = 64'd1 << FRAC_BITS;
  localparam longint unsigned EPS_L     = (ONE_L + 64'd50) / 64'd100;
  localparam longint unsigned EPS2_L    = EPS_L * EPS_L;
  localparam longint unsigned TENTH_L   = (ONE_L + 64'd5) / 64'd10;
  localparam longint unsigned DTRAW_L   = (ONE_L + 64'd5000) / 64'd10000;
  localparam longint unsigned DTMIN_L   = (DTRAW_L < 64'd1) ? 64'd1 : DTRAW_L;
  localparam longint unsigned MAG_CAP_L = 64'd1 << 38;

  // quotient bits of every divider: enough for the inverse-square factor
  localparam int DIV_Q_W   = 2 * FRAC_BITS - $clog2(TENTH_L) + 2;
  localparam int INV_DEN_W = D2_W - FRAC_BITS + 1;

  localparam int F_W    = FRAC_BITS + 1;          // unit factor, unit direction
  localparam int FS_W   = DIV_Q_W;                // selected factor
  localparam int FSQ_W  = 2 * F_W;
  localparam int FS2_W  = FSQ_W - FRAC_BITS;
  localparam int TERM_W = FRAC_BITS + 2;
  localparam int SMP_W  = FS2_W + TERM_W;
  localparam int SFP_W  = STR_W + FS_W;
  localparam int SF_W   = SFP_W - FRAC_BITS + 3;
  localparam int DT2_W  = 2 * DT_W - FRAC_BITS;
  localparam int SPL    = 24;                     // partial product split
  localparam int TOT_W  = SF_W + DT2_W;
  localparam int MAG_W  = 39;
  localparam int PRD_W  = F_W + MAG_W;
  localparam int DISP_W = PRD_W - FRAC_BITS;
  localparam int SUM_W  = DISP_W + 2;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_REPEL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FALLOFF  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DT       = 3'd7;

  // falloff codes
  localparam logic [1:0] FALL_LIN    = 2'd0;
  localparam logic [1:0] FALL_INV    = 2'd1;
  localparam logic [1:0] FALL_SMOOTH = 2'd2;

  localparam logic [STR_W-1:0] STRENGTH_RST = 32'd327680;
  localparam logic [R_W-1:0]   RADIUS_RST   = 31'd262144;
  localparam logic [1:0]       FALLOFF_RST  = FALL_INV;
  localparam logic [DT_W-1:0]  DT_RST       = 31'd1092;

  typedef struct packed {
    logic [2:0][XY_W-1:0] p;
    logic [2:0]           dvn;
    logic [2:0][R_W-1:0]  a;
    logic                 far;
    logic                 in_range;
    logic [D2_W-1:0]      d2;
  } side_t;

  typedef struct packed {
    logic [2:0][XY_W-1:0] p;
    logic [2:0]           dvn;
    logic                 in_range;
    logic [2:0][F_W-1:0]  u;
  } post_t;

  function automatic logic [XY_W-1:0] sat_xy(input logic [SUM_W-1:0] v);
    logic [SUM_W-XY_W:0] hi;
    logic [XY_W-1:0]     r;
    hi = v[SUM_W-1:XY_W-1];
    if ((&hi) || !(|hi)) begin
      r = v[XY_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(XY_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(XY_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/pad_div_pipe.sv =====
// ----------------------------------------------------------------------------
// pad_div_pipe
// Pipelined restoring divider, one quotient bit per stage. The high part of
// the numerator above Q_W bits must lie below the divisor.
// ----------------------------------------------------------------------------
module pad_div_pipe #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 32,
  parameter int Q_W   = 21
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o
);

  localparam int REM_W = DEN_W + 1;

  logic [REM_W-1:0] rem_q [Q_W];
  logic [Q_W-1:0]   lo_q  [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [REM_W-1:0] rem_in;
    logic [REM_W-1:0] rem_sh;
    logic [Q_W-1:0]   lo_in;
    logic [Q_W-1:0]   quo_in;
    logic [DEN_W-1:0] den_in;

    if (k == 0) begin : g_first
      assign rem_in = REM_W'(num_i[NUM_W-1:Q_W]);
      assign lo_in  = num_i[Q_W-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign lo_in  = lo_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign rem_sh = {rem_in[REM_W-2:0], lo_in[Q_W-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_sh >= {1'b0, den_in}) begin
          rem_q[k] <= rem_sh - {1'b0, den_in};
          quo_q[k] <= {quo_in[Q_W-2:0], 1'b1};
        end else begin
          rem_q[k] <= rem_sh;
          quo_q[k] <= {quo_in[Q_W-2:0], 1'b0};
        end
        lo_q[k]  <= {lo_in[Q_W-2:0], 1'b0};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[Q_W-1];

endmodule

// ===== hw/rtl/point_attractor_displace_core.sv =====
// ----------------------------------------------------------------------------
// point_attractor_displace_core
// Moves each 3-D point toward (or away from) an attractor target with a
// linear, inverse-square or smoothstep falloff inside a radius.
// ----------------------------------------------------------------------------
// Pipeline: front end, the 32-stage square root, the DIV_Q_W-stage
//   dividers and post processing, from input beat to output beat.
// Throughput: one beat per cycle; a stall on the output freezes the pipe.
// Reset: rst_ni clears all valid bits and loads register defaults; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module point_attractor_displace_core
  import pad_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 wr_en_i,
  input  logic [CFG_IDX_W-1:0] wr_idx_i,
  input  logic [XY_W-1:0]      wr_data_i,
  // input beats
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [XY_W-1:0]      pos_x_i,
  input  logic [XY_W-1:0]      pos_y_i,
  input  logic [XY_W-1:0]      pos_z_i,
  // output beats
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [XY_W-1:0]      new_x_o,
  output logic [XY_W-1:0]      new_y_o,
  output logic [XY_W-1:0]      new_z_o,
  output logic                 was_moved_o
);

  // Stage map: side_q[0..2] front end, side_q[3..SQ_END] square root,
  // side_q[..DIV_END] dividers, then ten stages of post processing.
  localparam int SQ_END  = 2 + SQ_N;
  localparam int DIV_END = SQ_END + DIV_Q_W;
  localparam int SIDE_N  = DIV_END + 1;
  localparam int POST_N  = 9;
  localparam int NSTG    = SIDE_N + POST_N + 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic                 repel_q;
  logic [2:0][XY_W-1:0] tgt_q;
  logic [STR_W-1:0]     strength_q;
  logic [R_W-1:0]       radius_q;
  logic [1:0]           falloff_q;
  logic [DT_W-1:0]      dt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repel_q    <= 1'b0;
      tgt_q      <= '0;
      strength_q <= STRENGTH_RST;
      radius_q   <= RADIUS_RST;
      falloff_q  <= FALLOFF_RST;
      dt_q       <= DT_RST;
    end else if (wr_en_i) begin
      case (wr_idx_i)
        REG_REPEL:    repel_q    <= wr_data_i[0];
        REG_TARGET_X: tgt_q[0]   <= wr_data_i;
        REG_TARGET_Y: tgt_q[1]   <= wr_data_i;
        REG_TARGET_Z: tgt_q[2]   <= wr_data_i;
        REG_STRENGTH: strength_q <= wr_data_i;
        REG_RADIUS:   radius_q   <= wr_data_i[R_W-1:0];
        REG_FALLOFF:  falloff_q  <= wr_data_i[1:0];
        REG_DT:       dt_q       <= wr_data_i[DT_W-1:0];
        default:      ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: the whole pipe advances unless the output beat is held.
  // --------------------------------------------------------------------------
  logic [NSTG-1:0] vld_q;
  logic            adv;
  logic            accept;

  assign adv        = !vld_q[NSTG-1] || !out_stall_i;
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], accept};
    end
  end

  // --------------------------------------------------------------------------
  // Front end: offsets, squares, squared distance and the inside test
  // --------------------------------------------------------------------------
  side_t                side_q [SIDE_N];
  side_t                side_s0;
  side_t                side_s2;
  logic [2:0][XY_W-1:0] pos_v;
  logic [2*R_W-1:0]     sqr_q [3];
  logic [2*R_W-1:0]     r2_q;
  logic [D2_W-1:0]      d2_sum;

  assign pos_v = {pos_z_i, pos_y_i, pos_x_i};

  always_comb begin
    side_s0 = '0;
    for (int i = 0; i < 3; i++) begin
      logic [XY_W:0] dv;
      logic [XY_W:0] dmag;
      dv   = {tgt_q[i][XY_W-1], tgt_q[i]} - {pos_v[i][XY_W-1], pos_v[i]};
      dmag = dv[XY_W] ? (~dv + 1'b1) : dv;
      side_s0.p[i]   = pos_v[i];
      side_s0.dvn[i] = dv[XY_W];
      side_s0.a[i]   = dmag[R_W-1:0];
      if (dmag >= {2'b00, radius_q}) begin
        side_s0.far = 1'b1;
      end
    end
  end

  assign d2_sum = D2_W'(sqr_q[0]) + D2_W'(sqr_q[1]) + D2_W'(sqr_q[2]);

  // inside the sphere and clear of the center
  always_comb begin
    side_s2          = side_q[1];
    side_s2.d2       = d2_sum;
    side_s2.in_range = !side_q[1].far && (d2_sum < D2_W'(r2_q))
                       && (d2_sum > D2_W'(EPS2_L));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_s0;
      for (int i = 0; i < 3; i++) begin
        sqr_q[i] <= side_q[0].a[i] * side_q[0].a[i];
      end
      r2_q      <= radius_q * radius_q;
      side_q[1] <= side_q[0];
      side_q[2] <= side_s2;
      for (int k = 3; k < SIDE_N; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Square root: one root bit per stage
  // --------------------------------------------------------------------------
  logic [SQ_REM_W-1:0] sq_rem_q  [SQ_N];
  logic [SQ_N-1:0]     sq_root_q [SQ_N];
  logic [D2_W-1:0]     sq_x_q    [SQ_N];

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    logic [SQ_REM_W-1:0] rem_in;
    logic [SQ_REM_W-1:0] rem_sh;
    logic [SQ_REM_W-1:0] trial;
    logic [SQ_N-1:0]     root_in;
    logic [D2_W-1:0]     x_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = side_q[2].d2;
    end else begin : g_next
      assign rem_in  = sq_rem_q[k-1];
      assign root_in = sq_root_q[k-1];
      assign x_in    = sq_x_q[k-1];
    end

    assign rem_sh = {rem_in[SQ_REM_W-3:0], x_in[D2_W-1:D2_W-2]};
    assign trial  = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (rem_sh >= trial) begin
          sq_rem_q[k]  <= rem_sh - trial;
          sq_root_q[k] <= {root_in[SQ_N-2:0], 1'b1};
        end else begin
          sq_rem_q[k]  <= rem_sh;
          sq_root_q[k] <= {root_in[SQ_N-2:0], 1'b0};
        end
        sq_x_q[k] <= {x_in[D2_W-3:0], 2'b00};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Dividers: linear factor, inverse-square factor, unit direction per axis
  // --------------------------------------------------------------------------
  logic [SQ_N-1:0]      dist_root;
  logic [DIV_Q_W-1:0]   quo_lin;
  logic [DIV_Q_W-1:0]   quo_inv;
  logic [DIV_Q_W-1:0]   quo_u [3];
  logic [INV_DEN_W-1:0] inv_den;

  assign dist_root = sq_root_q[SQ_N-1];
  assign inv_den = INV_DEN_W'(side_q[SQ_END].d2 >> FRAC_BITS) + INV_DEN_W'(TENTH_L);

  pad_div_pipe #(
    .NUM_W (SQ_N + FRAC_BITS),
    .DEN_W (R_W),
    .Q_W   (DIV_Q_W)
  ) u_div_lin (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i ({dist_root, {FRAC_BITS{1'b0}}}),
    .den_i (radius_q),
    .quo_o (quo_lin)
  );

  pad_div_pipe #(
    .NUM_W (2 * FRAC_BITS + 1),
    .DEN_W (INV_DEN_W),
    .Q_W   (DIV_Q_W)
  ) u_div_inv (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i ({1'b1, {(2 * FRAC_BITS){1'b0}}}),
    .den_i (inv_den),
    .quo_o (quo_inv)
  );

  for (genvar i = 0; i < 3; i++) begin : g_udiv
    pad_div_pipe #(
      .NUM_W (R_W + FRAC_BITS),
      .DEN_W (SQ_N),
      .Q_W   (DIV_Q_W)
    ) u_div_u (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i ({side_q[SQ_END].a[i], {FRAC_BITS{1'b0}}}),
      .den_i (dist_root),
      .quo_o (quo_u[i])
    );
  end

  // --------------------------------------------------------------------------
  // Post processing: factor, magnitude, displacement, saturation
  // --------------------------------------------------------------------------
  post_t               post_q [POST_N];
  post_t               post_s0;
  logic [F_W-1:0]      flin_s;
  logic [F_W-1:0]      flin1_q, flin2_q;
  logic [FSQ_W-1:0]    fsq1_q;
  logic [FS_W-1:0]     finv1_q, finv2_q;
  logic [SMP_W-1:0]    smp2_q;
  logic [TERM_W-1:0]   term_s;
  logic [FS_W-1:0]     fsel_s;
  logic [STR_W-1:0]    str_abs;
  logic [DT_W-1:0]     dt_c;
  logic [SFP_W-1:0]    sfp3_q;
  logic [2*DT_W-1:0]   dtsq3_q;
  logic [SF_W-1:0]     sf_s, sf4_q;
  logic [DT2_W-1:0]    dt24_q;
  logic [2*SPL-1:0]    ll5_q;
  logic [DT2_W-1:0]    lh5_q;
  logic [SF_W-1:0]     hl5_q;
  logic [TOT_W-2*SPL-1:0] hh5_q;
  logic [2*SPL-1:0]    ll6_q;
  logic [TOT_W-1:0]    mid6_q;
  logic [TOT_W-2*SPL-1:0] hh6_q;
  logic [TOT_W-1:0]    tot7_q;
  logic [TOT_W-FRAC_BITS-1:0] tot_sh;
  logic [MAG_W-1:0]    mag8_q;
  logic [PRD_W-1:0]    prod9_q [3];
  logic                move_neg;
  logic [2:0][XY_W-1:0] new_q;
  logic                moved_q;

  assign flin_s = F_W'(ONE_L) - quo_lin[F_W-1:0];

  always_comb begin
    post_s0          = '0;
    post_s0.p        = side_q[DIV_END].p;
    post_s0.dvn      = side_q[DIV_END].dvn;
    post_s0.in_range = side_q[DIV_END].in_range;
    for (int i = 0; i < 3; i++) begin
      // a unit component never exceeds one
      if (quo_u[i] > DIV_Q_W'(ONE_L)) begin
        post_s0.u[i] = F_W'(ONE_L);
      end else begin
        post_s0.u[i] = quo_u[i][F_W-1:0];
      end
    end
  end

  assign term_s = TERM_W'(3 * ONE_L) - {flin1_q, 1'b0};

  always_comb begin
    case (falloff_q)
      FALL_INV:    fsel_s = finv2_q;
      FALL_SMOOTH: fsel_s = FS_W'(smp2_q >> FRAC_BITS);
      default:     fsel_s = FS_W'(flin2_q);
    endcase
  end

  assign str_abs  = strength_q[STR_W-1] ? (~strength_q + 1'b1) : strength_q;
  assign dt_c     = (dt_q < DT_W'(DTMIN_L)) ? DT_W'(DTMIN_L) : dt_q;
  assign sf_s     = SF_W'(sfp3_q >> FRAC_BITS);
  assign tot_sh   = tot7_q[TOT_W-1:FRAC_BITS];
  assign move_neg = strength_q[STR_W-1] ^ repel_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // P1: linear factor and its square, clamp the direction
      post_q[0] <= post_s0;
      flin1_q   <= flin_s;
      fsq1_q    <= flin_s * flin_s;
      finv1_q   <= quo_inv;
      // P2: smoothstep product
      flin2_q   <= flin1_q;
      finv2_q   <= finv1_q;
      smp2_q    <= fsq1_q[FSQ_W-1:FRAC_BITS] * term_s;
      // P3: pick the factor, scale by strength; square dt alongside
      sfp3_q    <= str_abs * fsel_s;
      dtsq3_q   <= dt_c * dt_c;
      // P4: times five, dt squared in fixed point
      sf4_q     <= (sf_s << 2) + sf_s;
      dt24_q    <= dtsq3_q[2*DT_W-1:FRAC_BITS];
      // P5: partial products of the wide magnitude product
      ll5_q     <= sf4_q[SPL-1:0] * dt24_q[SPL-1:0];
      lh5_q     <= DT2_W'(sf4_q[SPL-1:0] * dt24_q[DT2_W-1:SPL]);
      hl5_q     <= SF_W'(sf4_q[SF_W-1:SPL] * dt24_q[SPL-1:0]);
      hh5_q     <= sf4_q[SF_W-1:SPL] * dt24_q[DT2_W-1:SPL];
      // P6: fold the middle terms
      ll6_q     <= ll5_q;
      hh6_q     <= hh5_q;
      mid6_q    <= TOT_W'(lh5_q) + TOT_W'(hl5_q);
      // P7: full product
      tot7_q    <= TOT_W'(ll6_q) + (mid6_q << SPL) + (TOT_W'(hh6_q) << (2 * SPL));
      // P8: saturate the magnitude
      mag8_q    <= (tot_sh > (TOT_W-FRAC_BITS)'(MAG_CAP_L)) ? MAG_W'(MAG_CAP_L)
                                                             : MAG_W'(tot_sh);
      // P9: per-axis displacement
      for (int i = 0; i < 3; i++) begin
        prod9_q[i] <= post_q[7].u[i] * mag8_q;
      end
      for (int k = 1; k < POST_N; k++) begin
        post_q[k] <= post_q[k-1];
      end
      // P10: apply and saturate, or pass the point through
      for (int i = 0; i < 3; i++) begin
        logic [SUM_W-1:0] pext;
        logic [SUM_W-1:0] dext;
        pext = SUM_W'($signed(post_q[8].p[i]));
        dext = SUM_W'(prod9_q[i][PRD_W-1:FRAC_BITS]);
        if (!post_q[8].in_range) begin
          new_q[i] <= post_q[8].p[i];
        end else if (post_q[8].dvn[i] ^ move_neg) begin
          new_q[i] <= sat_xy(pext - dext);
        end else begin
          new_q[i] <= sat_xy(pext + dext);
        end
      end
      moved_q <= post_q[8].in_range;
    end
  end

  assign out_valid_o = vld_q[NSTG-1];
  assign new_x_o     = new_q[0];
  assign new_y_o     = new_q[1];
  assign new_z_o     = new_q[2];
  assign was_moved_o = moved_q;

endmodule

// ===== hw/rtl/pad_checker.sv =====
// ----------------------------------------------------------------------------
// pad_checker
// Port-level checks for the point attractor displacement pipeline.
// ----------------------------------------------------------------------------
module pad_checker
  import pad_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [XY_W-1:0]      new_x_o,
  input logic [XY_W-1:0]      new_y_o,
  input logic [XY_W-1:0]      new_z_o,
  input logic                 was_moved_o
);

  // hold a stalled output beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(new_x_o) && $stable(new_y_o)
      && $stable(new_z_o) && $stable(was_moved_o))
    else $error("stalled output beat changed");

  // input stalls only when the output beat is held
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back pressure");

  // the pipe comes out of reset empty
  a_rst_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind point_attractor_displace_core pad_checker u_pad_checker (.*);
